FILE: rtl/pdd_pkg.sv
// pdd_pkg: shared constants, codes, state types and the arctangent table
// for the polar density grid; no dependencies
package pdd_pkg;

    // default geometry
    localparam int RINGS_DEF      = 20;
    localparam int SECTORS_DEF    = 60;
    localparam int COUNT_BITS_DEF = 16;

    // register reset values
    localparam logic [7:0] MAX_RADIUS_RST = 8'd80;
    localparam logic [7:0] MIN_RADIUS_RST = 8'd2;

    // configuration register indexes
    localparam logic CFG_MAX_RADIUS = 1'b0;
    localparam logic CFG_MIN_RADIUS = 1'b1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_BINNED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    // angles in q16 degrees
    localparam int          ANG_W        = 23;
    localparam int          THETA_W      = 25;
    localparam logic [22:0] DEG90_Q16    = 23'd5898240;
    localparam logic [24:0] DEG360_Q16   = 25'd23592960;
    localparam int          CORDIC_STEPS = 16;
    localparam int          ATAN_W       = 22;

    // main sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQ,
        S_RANGE,
        S_RING_MUL,
        S_RING_CMP,
        S_ANGLE,
        S_SECTOR,
        S_MEM_RD,
        S_MEM_UPD,
        S_VALUE,
        S_DONE
    } t_seq_state;

    // angle unit states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER
    } t_cordic_state;

    // round(atan(2^-i) degrees * 65536)
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [3:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            4'd0:    v = 22'd2949120;
            4'd1:    v = 22'd1740967;
            4'd2:    v = 22'd919879;
            4'd3:    v = 22'd466945;
            4'd4:    v = 22'd234379;
            4'd5:    v = 22'd117304;
            4'd6:    v = 22'd58666;
            4'd7:    v = 22'd29335;
            4'd8:    v = 22'd14668;
            4'd9:    v = 22'd7334;
            4'd10:   v = 22'd3667;
            4'd11:   v = 22'd1833;
            4'd12:   v = 22'd917;
            4'd13:   v = 22'd458;
            4'd14:   v = 22'd229;
            4'd15:   v = 22'd115;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/pdd_grid_mem.sv
// pdd_grid_mem: single write, single read synchronous memory holding the
// cell counters; read data registered, no dependencies
module pdd_grid_mem #(
    parameter int DEPTH  = 1200,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pdd_cordic.sv
// pdd_cordic: first quadrant angle of two positive magnitudes, one
// normalising shift or one vectoring step per cycle; uses pdd_pkg
module pdd_cordic (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [23:0]              i_ax,
    input  logic [23:0]              i_ay,
    output logic                     o_busy,
    output logic [pdd_pkg::ANG_W-1:0] o_angle
);

    localparam logic signed [33:0] NORM_LIM = 34'sd1073741824;

    pdd_pkg::t_cordic_state r_state, n_state;
    logic signed [33:0] r_cx, r_cy;
    logic signed [24:0] r_z;
    logic [3:0]         r_i;
    logic [pdd_pkg::ANG_W-1:0] r_angle;

    logic signed [33:0] s_dx, s_dy;
    logic signed [24:0] s_atan, s_z_next;
    logic               s_norm_done;

    // step operands
    always_comb begin
        s_dx        = r_cy >>> r_i;
        s_dy        = r_cx >>> r_i;
        s_atan      = 25'(pdd_pkg::atan_q16(r_i));
        s_z_next    = r_cy[33] ? r_z - s_atan : r_z + s_atan;
        s_norm_done = (r_cx >= NORM_LIM) || (r_cy >= NORM_LIM);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdd_pkg::CS_IDLE: if (i_start) n_state = pdd_pkg::CS_NORM;
            pdd_pkg::CS_NORM: if (s_norm_done) n_state = pdd_pkg::CS_ITER;
            pdd_pkg::CS_ITER: if (r_i == 4'(pdd_pkg::CORDIC_STEPS - 1)) n_state = pdd_pkg::CS_IDLE;
            default:          n_state = pdd_pkg::CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy  = (r_state != pdd_pkg::CS_IDLE);
        o_angle = r_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdd_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            pdd_pkg::CS_IDLE: begin
                r_cx <= 34'(i_ax);
                r_cy <= 34'(i_ay);
                r_z  <= '0;
                r_i  <= '0;
            end
            pdd_pkg::CS_NORM: begin
                if (!s_norm_done) begin
                    r_cx <= r_cx <<< 1;
                    r_cy <= r_cy <<< 1;
                end
            end
            pdd_pkg::CS_ITER: begin
                if (r_cy[33]) begin
                    r_cx <= r_cx - s_dx;
                    r_cy <= r_cy + s_dy;
                end else begin
                    r_cx <= r_cx + s_dx;
                    r_cy <= r_cy - s_dy;
                end
                r_z <= s_z_next;
                r_i <= r_i + 4'd1;
                // clamp the angle to the first quadrant on every step; the last step leaves the result
                if (s_z_next < 0) begin
                    r_angle <= '0;
                end else if (s_z_next > 25'(pdd_pkg::DEG90_Q16)) begin
                    r_angle <= pdd_pkg::DEG90_Q16;
                end else begin
                    r_angle <= s_z_next[pdd_pkg::ANG_W-1:0];
                end
            end
            default: begin
                r_i <= '0;
            end
        endcase
    end

endmodule

FILE: rtl/pdd_divider.sv
// pdd_divider: restoring unsigned divider, one quotient bit per cycle,
// used for the scaled cell value; no dependencies
module pdd_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   s_shift;
    logic             s_ge;

    // trial subtract
    always_comb begin
        s_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        s_ge    = (s_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_shift - {1'b0, r_den} : s_shift;
            r_quo <= {r_quo[NUM_W-2:0], s_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/polar_density_descriptor.sv
// polar_density_descriptor: top level, request sequencer around the grid
// memory, the angle unit and the divider; uses pdd_pkg and the pdd_ modules
//
// One request is worked at a time; each gives one result word. An add
// squares the point, tests its range, searches the ring one candidate per
// multiply and compare state pair while the angle unit runs, takes the
// sector from the angle by a reciprocal multiplication, does a
// read-modify-write of the counter and then divides for the scaled value,
// one bit per cycle; the slower of the angle unit and the ring search sets
// when the sector is taken, and a dropped point ends after the range test.
// A read does one memory read and, while the peak is nonzero, one division;
// a clear zeroes the RINGS*SECTORS cells, one cell per cycle.
// After reset the same clearing pass runs before the first request is
// taken; configuration writes are taken at any time.
// The next request is taken while the previous result still waits.
module polar_density_descriptor #(
    parameter int RINGS      = pdd_pkg::RINGS_DEF,
    parameter int SECTORS    = pdd_pkg::SECTORS_DEF,
    parameter int COUNT_BITS = pdd_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // point_x, point_y, ring_sel, sector_sel
    input  logic [1:0]  i_s_tuser,  // req_type
    // result words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // ring_index, sector_index, cell_count,
                                    // cell_value, max_count
    output logic [1:0]  o_m_tuser,  // status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CELLS     = RINGS * SECTORS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int RING_W    = $clog2(RINGS + 1);
    localparam int SEC_W     = $clog2(SECTORS + 1);
    localparam int RSQ       = RINGS * RINGS;
    localparam int RSQ_W     = $clog2(RSQ + 1);
    localparam int B_W       = 16 + RING_W;
    localparam int BSQ_W     = 2 * B_W;
    localparam int T_W       = 48 + RSQ_W;
    localparam int CMP_W     = (T_W > BSQ_W) ? T_W : BSQ_W;
    localparam int SNUM_W    = pdd_pkg::THETA_W + SEC_W + 1;
    // 360 degrees in q16 is 45 * 2^19
    localparam int SV_SHIFT  = 19;
    localparam int SV_W      = SNUM_W - SV_SHIFT;
    localparam int SQ_W      = SV_W + 15;
    localparam int RECIP_SH  = 20;
    localparam logic [14:0] RECIP45 = 15'd23302;
    localparam int DIV_NW    = COUNT_BITS + 8;
    localparam int DIV_DW    = COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    pdd_pkg::t_seq_state r_state, n_state;

    // configuration
    logic [7:0] r_max_rad, r_min_rad;

    // request and work registers
    logic [1:0]               r_status;
    logic signed [23:0]       r_x, r_y;
    logic [23:0]              r_ax, r_ay;
    logic [47:0]              r_sqx, r_sqy;
    logic [31:0]              r_hi2, r_lo2;
    logic [T_W-1:0]           r_target;
    logic [B_W-1:0]           r_b;
    logic [BSQ_W-1:0]         r_bsq;
    logic [RING_W-1:0]        r_k;
    logic [SV_W-1:0]          r_sv;
    logic                     r_in_grid;
    logic [ADDR_W-1:0]        r_addr;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic                     r_clr_report;
    logic [COUNT_BITS-1:0]    r_cnt, r_peak;
    logic [7:0]               r_val;
    logic [4:0]               r_ring_o;
    logic [5:0]               r_sec_o;

    // result register
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic [55:0]              r_out_data;

    // interconnect
    logic                     s_accept;
    logic                     s_mem_we;
    logic [ADDR_W-1:0]        s_mem_waddr;
    logic [COUNT_BITS-1:0]    s_mem_wdata;
    logic [COUNT_BITS-1:0]    s_rdata;
    logic                     s_cor_start, s_cor_busy;
    logic [pdd_pkg::ANG_W-1:0] s_cor_angle;
    logic                     s_div_start, s_div_busy;
    logic [DIV_NW-1:0]        s_div_num, s_div_quo;
    logic [DIV_DW-1:0]        s_div_den;
    logic                     s_out_load;

    // combinational datapath values
    logic [1:0]               s_req;
    logic signed [23:0]       s_x, s_y;
    logic [4:0]               s_rsel;
    logic [5:0]               s_ssel;
    logic                     s_sel_ok;
    logic [47:0]              s_r2;
    logic                     s_drop;
    logic                     s_ring_hit;
    logic [pdd_pkg::ANG_W-1:0] s_a;
    logic [pdd_pkg::THETA_W-1:0] s_theta;
    logic [SNUM_W-1:0]        s_snum;
    logic [SQ_W-1:0]          s_sq, s_sec_q;
    logic [SEC_W-1:0]         s_sec1;
    logic [COUNT_BITS-1:0]    s_cnt_inc, s_cnt_res, s_peak_new;

    // field unpacking and accept
    always_comb begin
        s_accept = i_s_tvalid && o_s_tready;
        s_req    = i_s_tuser;
        s_x      = i_s_tdata[23:0];
        s_y      = i_s_tdata[47:24];
        s_rsel   = i_s_tdata[52:48];
        s_ssel   = i_s_tdata[58:53];
        s_sel_ok = (32'(s_rsel) < RINGS) && (32'(s_ssel) < SECTORS);
    end

    // range, ring, angle and sector arithmetic
    always_comb begin
        s_r2       = r_sqx + r_sqy;
        s_drop     = ({16'd0, s_r2} > {32'd0, r_hi2}) || (s_r2 < {16'd0, r_lo2});
        s_ring_hit = (CMP_W'(r_bsq) >= CMP_W'(r_target)) || (r_k == RING_W'(RINGS));
        if (r_ay == '0) begin
            s_a = '0;
        end else if (r_ax == '0) begin
            s_a = pdd_pkg::DEG90_Q16;
        end else begin
            s_a = s_cor_angle;
        end
        if (!r_x[23] && !r_y[23]) begin
            s_theta = 25'(s_a);
        end else if (r_x[23] && !r_y[23]) begin
            s_theta = {1'b0, pdd_pkg::DEG90_Q16, 1'b0} - 25'(s_a);
        end else if (r_x[23]) begin
            s_theta = {1'b0, pdd_pkg::DEG90_Q16, 1'b0} + 25'(s_a);
        end else begin
            s_theta = {pdd_pkg::DEG90_Q16, 2'b00} - 25'(s_a);
        end
        // ceiling numerator of theta * SECTORS over a full turn
        s_snum = SNUM_W'(s_theta) * SNUM_W'(SECTORS)
               + SNUM_W'(pdd_pkg::DEG360_Q16) - SNUM_W'(1);
        // floor of r_sv / 45 by reciprocal, exact while r_sv stays below 2^14
        s_sq    = SQ_W'(r_sv) * SQ_W'(RECIP45);
        s_sec_q = s_sq >> RECIP_SH;
        if (s_sec_q == '0) begin
            s_sec1 = SEC_W'(1);
        end else if (s_sec_q > SQ_W'(SECTORS)) begin
            s_sec1 = SEC_W'(SECTORS);
        end else begin
            s_sec1 = SEC_W'(s_sec_q);
        end
    end

    // counter update
    always_comb begin
        s_cnt_inc = (s_rdata == COUNT_MAX) ? s_rdata : s_rdata + 1'b1;
        if (r_status == pdd_pkg::ST_READ) begin
            s_cnt_res  = r_in_grid ? s_rdata : '0;
            s_peak_new = r_peak;
        end else begin
            s_cnt_res  = s_cnt_inc;
            s_peak_new = (s_cnt_inc > r_peak) ? s_cnt_inc : r_peak;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdd_pkg::S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = r_clr_report ? pdd_pkg::S_DONE : pdd_pkg::S_IDLE;
                end
            end
            pdd_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_req == pdd_pkg::REQ_ADD) begin
                        n_state = pdd_pkg::S_SQ;
                    end else if (s_req == pdd_pkg::REQ_CLEAR) begin
                        n_state = pdd_pkg::S_CLEAR;
                    end else begin
                        n_state = pdd_pkg::S_MEM_RD;
                    end
                end
            end
            pdd_pkg::S_SQ:       n_state = pdd_pkg::S_RANGE;
            pdd_pkg::S_RANGE:    n_state = s_drop ? pdd_pkg::S_DONE : pdd_pkg::S_RING_MUL;
            pdd_pkg::S_RING_MUL: n_state = pdd_pkg::S_RING_CMP;
            pdd_pkg::S_RING_CMP: n_state = s_ring_hit ? pdd_pkg::S_ANGLE : pdd_pkg::S_RING_MUL;
            pdd_pkg::S_ANGLE:    if (!s_cor_busy) n_state = pdd_pkg::S_SECTOR;
            pdd_pkg::S_SECTOR:   n_state = pdd_pkg::S_MEM_RD;
            pdd_pkg::S_MEM_RD:   n_state = pdd_pkg::S_MEM_UPD;
            pdd_pkg::S_MEM_UPD: begin
                n_state = (s_peak_new == '0) ? pdd_pkg::S_DONE : pdd_pkg::S_VALUE;
            end
            pdd_pkg::S_VALUE:    if (!s_div_busy) n_state = pdd_pkg::S_DONE;
            pdd_pkg::S_DONE:     if (!r_out_valid || i_m_tready) n_state = pdd_pkg::S_IDLE;
            default:             n_state = pdd_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_s_tready  = (r_state == pdd_pkg::S_IDLE);
        s_mem_we    = 1'b0;
        s_mem_waddr = r_addr;
        s_mem_wdata = s_cnt_inc;
        s_cor_start = 1'b0;
        s_div_start = 1'b0;
        s_div_num   = DIV_NW'(s_cnt_res) * DIV_NW'(255);
        s_div_den   = DIV_DW'(s_peak_new);
        s_out_load  = 1'b0;
        case (r_state)
            pdd_pkg::S_CLEAR: begin
                s_mem_we    = 1'b1;
                s_mem_waddr = r_clr_addr;
                s_mem_wdata = '0;
            end
            pdd_pkg::S_RANGE: begin
                s_cor_start = !s_drop && (r_ax != '0) && (r_ay != '0);
            end
            pdd_pkg::S_MEM_UPD: begin
                s_mem_we    = (r_status == pdd_pkg::ST_BINNED);
                s_div_start = (s_peak_new != '0);
            end
            pdd_pkg::S_DONE: begin
                s_out_load = !r_out_valid || i_m_tready;
            end
            default: begin
                s_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pdd_pkg::S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_peak       <= '0;
            r_max_rad    <= pdd_pkg::MAX_RADIUS_RST;
            r_min_rad    <= pdd_pkg::MIN_RADIUS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pdd_pkg::CFG_MAX_RADIUS) begin
                    r_max_rad <= i_cfg_data;
                end else begin
                    r_min_rad <= i_cfg_data;
                end
            end
            // clearing sweep
            if (r_state == pdd_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_peak     <= '0;
            end else begin
                r_clr_addr <= '0;
            end
            if (s_accept) begin
                r_clr_report <= (s_req == pdd_pkg::REQ_CLEAR);
            end
            if (r_state == pdd_pkg::S_MEM_UPD) begin
                r_peak <= s_peak_new;
            end
            // result word handshake
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pdd_pkg::S_CLEAR: begin
                r_status <= pdd_pkg::ST_CLEARED;
                r_ring_o <= '0;
                r_sec_o  <= '0;
                r_cnt    <= '0;
                r_val    <= '0;
            end
            pdd_pkg::S_IDLE: begin
                r_x       <= s_x;
                r_y       <= s_y;
                r_ax      <= s_x[23] ? 24'(-s_x) : 24'(s_x);
                r_ay      <= s_y[23] ? 24'(-s_y) : 24'(s_y);
                r_ring_o  <= s_rsel;
                r_sec_o   <= s_ssel;
                r_in_grid <= s_sel_ok;
                r_addr    <= ADDR_W'(32'(s_rsel) * SECTORS + 32'(s_ssel));
                r_val     <= '0;
                r_status  <= (s_req == pdd_pkg::REQ_ADD) ? pdd_pkg::ST_BINNED
                                                         : pdd_pkg::ST_READ;
            end
            pdd_pkg::S_SQ: begin
                r_sqx <= 48'(r_ax) * 48'(r_ax);
                r_sqy <= 48'(r_ay) * 48'(r_ay);
                r_hi2 <= {16'(r_max_rad) * 16'(r_max_rad), 16'd0};
                r_lo2 <= {16'(r_min_rad) * 16'(r_min_rad), 16'd0};
            end
            pdd_pkg::S_RANGE: begin
                r_target <= T_W'(s_r2) * T_W'(RSQ);
                r_b      <= B_W'({r_max_rad, 8'd0});
                r_k      <= RING_W'(1);
                if (s_drop) begin
                    r_status <= pdd_pkg::ST_DROPPED;
                    r_ring_o <= '0;
                    r_sec_o  <= '0;
                    r_cnt    <= '0;
                    r_val    <= '0;
                end
            end
            pdd_pkg::S_RING_MUL: begin
                r_bsq <= BSQ_W'(r_b) * BSQ_W'(r_b);
            end
            pdd_pkg::S_RING_CMP: begin
                if (s_ring_hit) begin
                    r_ring_o <= 5'(r_k - 1'b1);
                end else begin
                    r_k <= r_k + 1'b1;
                    r_b <= r_b + B_W'({r_max_rad, 8'd0});
                end
            end
            pdd_pkg::S_ANGLE: begin
                r_sv <= SV_W'(s_snum >> SV_SHIFT);
            end
            pdd_pkg::S_SECTOR: begin
                r_sec_o <= 6'(s_sec1 - 1'b1);
                r_addr  <= ADDR_W'(32'(r_k - 1'b1) * SECTORS + 32'(s_sec1 - 1'b1));
            end
            pdd_pkg::S_MEM_UPD: begin
                r_cnt <= s_cnt_res;
                r_val <= '0;
            end
            pdd_pkg::S_VALUE: begin
                r_val <= s_div_quo[7:0];
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out_status <= r_status;
            r_out_data   <= {5'd0, 16'(r_peak), r_val, 16'(r_cnt), r_sec_o, r_ring_o};
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tuser   = r_out_status;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    pdd_grid_mem #(
        .DEPTH  (CELLS),
        .WIDTH  (COUNT_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_mem_we),
        .i_waddr (s_mem_waddr),
        .i_wdata (s_mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (s_rdata)
    );

    pdd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_cor_start),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .o_busy  (s_cor_busy),
        .o_angle (s_cor_angle)
    );

    pdd_divider #(
        .NUM_W (DIV_NW),
        .DEN_W (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (s_div_num),
        .i_den   (s_div_den),
        .o_busy  (s_div_busy),
        .o_quo   (s_div_quo)
    );

endmodule

FILE: rtl/pdd_checker.sv
// pdd_checker: port level checks of the polar density grid, bound to the
// top level; uses pdd_pkg for the status codes
module pdd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // clearing pass follows reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request taken during clearing pass");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request taken while busy");

    // dropped point carries no cell
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == pdd_pkg::ST_DROPPED) |-> (o_m_tdata[34:0] == '0))
        else $error("dropped point with cell fields");

    // clear result is empty
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == pdd_pkg::ST_CLEARED) |-> (o_m_tdata == '0))
        else $error("clear result not empty");

endmodule

bind polar_density_descriptor pdd_checker u_pdd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/polar_density_descriptor_tb.sv
// polar_density_descriptor_tb: self-checking bench for the polar density grid
// holds its own grid predictor in a small scoreboard class; uses pdd_pkg
// and the polar_density_descriptor top level

typedef struct {
    logic [1:0]  status;
    logic [4:0]  ring;
    logic [5:0]  sector;
    logic [15:0] count;
    logic [7:0]  value;
    logic [15:0] peak;
} t_grid_result;

class t_grid_scoreboard;
    localparam int NRINGS   = 20;
    localparam int NSECTORS = 60;
    localparam longint DEG90  = 5898240;
    localparam longint DEG360 = 23592960;

    // round(atan(2^-i) degrees) in q16
    longint      atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115};
    logic [15:0] grid[NRINGS*NSECTORS];
    logic [15:0] peak;
    logic [7:0]  max_radius;
    logic [7:0]  min_radius;
    t_grid_result pending_q[$];
    int          failures;
    int          checked;
    int          binned;
    int          dropped;

    function new();
        foreach (grid[i]) grid[i] = '0;
        peak       = '0;
        max_radius = pdd_pkg::MAX_RADIUS_RST;
        min_radius = pdd_pkg::MIN_RADIUS_RST;
        failures   = 0;
        checked    = 0;
        binned     = 0;
        dropped    = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
        if (idx == pdd_pkg::CFG_MAX_RADIUS) max_radius = val;
        else min_radius = val;
    endfunction

    function logic [7:0] scaled(logic [15:0] cnt);
        if (peak == 0) return 8'd0;
        return 8'((longint'(cnt) * 255) / longint'(peak));
    endfunction

    // first quadrant angle by vectoring, both operands positive
    function longint quadrant_angle(longint ax, longint ay);
        longint cx, cy, z, dx, dy;
        cx = ax;
        cy = ay;
        z  = 0;
        while (cx < (longint'(1) << 30) && cy < (longint'(1) << 30)) begin
            cx = cx * 2;
            cy = cy * 2;
        end
        for (int i = 0; i < 16; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += atan_tab[i];
            end else begin
                cx -= dx; cy += dy; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > DEG90) z = DEG90;
        return z;
    endfunction

    // work out the result word for one accepted request
    function void note_request(logic [1:0] req, logic signed [23:0] px,
                               logic signed [23:0] py, logic [4:0] rs, logic [5:0] ss);
        t_grid_result e;
        longint x, y, r2, hi, lo, tgt, b, ax, ay, a, theta, num;
        int ring, sector, idx;
        e = '{default: '0};
        if (req == pdd_pkg::REQ_ADD) begin
            x  = px;
            y  = py;
            r2 = x*x + y*y;
            hi = longint'(max_radius) * 256;
            lo = longint'(min_radius) * 256;
            if (r2 > hi*hi || r2 < lo*lo) begin
                e.status = pdd_pkg::ST_DROPPED;
                dropped++;
            end else begin
                tgt  = r2 * NRINGS * NRINGS;
                ring = NRINGS;
                for (int k = 1; k <= NRINGS; k++) begin
                    b = hi * k;
                    if (b*b >= tgt) begin
                        ring = k;
                        break;
                    end
                end
                ax = x < 0 ? -x : x;
                ay = y < 0 ? -y : y;
                if (ay == 0) a = 0;
                else if (ax == 0) a = DEG90;
                else a = quadrant_angle(ax, ay);
                if (x == 0 && y == 0) theta = 0;
                else if (x >= 0 && y >= 0) theta = a;
                else if (x < 0 && y >= 0) theta = 2*DEG90 - a;
                else if (x < 0) theta = 2*DEG90 + a;
                else theta = 4*DEG90 - a;
                num    = theta * NSECTORS;
                sector = int'((num + DEG360 - 1) / DEG360);
                if (sector < 1) sector = 1;
                if (sector > NSECTORS) sector = NSECTORS;
                idx = (ring-1)*NSECTORS + sector - 1;
                if (grid[idx] != 16'hFFFF) grid[idx]++;
                if (grid[idx] > peak) peak = grid[idx];
                e.status = pdd_pkg::ST_BINNED;
                e.ring   = 5'(ring-1);
                e.sector = 6'(sector-1);
                e.count  = grid[idx];
                e.value  = scaled(grid[idx]);
                binned++;
            end
        end else if (req == pdd_pkg::REQ_CLEAR) begin
            foreach (grid[i]) grid[i] = '0;
            peak     = '0;
            e.status = pdd_pkg::ST_CLEARED;
        end else begin
            // read, and the spare code behaves the same
            e.status = pdd_pkg::ST_READ;
            e.ring   = rs;
            e.sector = ss;
            if (rs < NRINGS && ss < NSECTORS) e.count = grid[rs*NSECTORS + ss];
            e.value = scaled(e.count);
        end
        e.peak = peak;
        pending_q = {pending_q, e};
    endfunction

    function void mismatch(string field, longint exp_v, longint act_v);
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        failures++;
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(logic [1:0] st, logic [55:0] d);
        t_grid_result e;
        checked++;
        if (pending_q.size() == 0) begin
            $error("result word with nothing expected: status %0d data %h", st, d);
            failures++;
            return;
        end
        e = pending_q.pop_front();
        if (st !== e.status)        mismatch("status", e.status, st);
        if (d[4:0] !== e.ring)      mismatch("ring_index", e.ring, d[4:0]);
        if (d[10:5] !== e.sector)   mismatch("sector_index", e.sector, d[10:5]);
        if (d[26:11] !== e.count)   mismatch("cell_count", e.count, d[26:11]);
        if (d[34:27] !== e.value)   mismatch("cell_value", e.value, d[34:27]);
        if (d[50:35] !== e.peak)    mismatch("max_count", e.peak, d[50:35]);
        if (d[55:51] !== 5'd0)      mismatch("tdata padding", 0, d[55:51]);
    endfunction
endclass

module polar_density_descriptor_tb;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam longint     LIMIT     = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;  // point_x, point_y, ring_sel, sector_sel
    logic [1:0]  i_s_tuser;  // req_type
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;  // ring_index, sector_index, cell_count, cell_value, max_count
    logic [1:0]  o_m_tuser;  // status
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    t_grid_scoreboard sb = new();
    bit     quiet;
    int     hold_asks = 0;
    longint cycles = 0;
    int     sent;

    // reusable points so that cells climb well above one
    logic signed [23:0] hot_x[8];
    logic signed [23:0] hot_y[8];

    polar_density_descriptor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random back-pressure, a long hold when asked
    initial begin
        int holds_done;
        holds_done = 0;
        i_m_tready = 1'b0;
        forever begin
            if (hold_asks > holds_done) begin
                holds_done++;
                repeat (400) begin
                    @(negedge i_clk);
                    i_m_tready = 1'b0;
                    @(posedge i_clk);
                end
            end
            @(negedge i_clk);
            i_m_tready = quiet || ($urandom_range(99) >= 23);
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tuser, o_m_tdata);
        end
    end

    // offer one request word, called at a falling edge, returns at one
    task automatic send_req(logic [1:0] req, logic signed [23:0] px,
                            logic signed [23:0] py, logic [4:0] rs, logic [5:0] ss);
        while (!quiet && $urandom_range(99) < 23) begin
            i_s_tvalid = 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = req;
        i_s_tdata  = {5'd0, ss, rs, py, px};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req, px, py, rs, ss);
        sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic add_point(logic signed [23:0] px, logic signed [23:0] py);
        send_req(pdd_pkg::REQ_ADD, px, py, 5'($urandom), 6'($urandom));
    endtask

    task automatic read_cell(logic [4:0] rs, logic [5:0] ss);
        send_req(pdd_pkg::REQ_READ, 24'($urandom), 24'($urandom), rs, ss);
    endtask

    // wait until every expected word is back, then let the block settle
    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // random part of one phase, points scaled to the current outer limit
    task automatic random_phase(int n);
        int lim, pick, h;
        lim = (sb.max_radius == 0) ? 256 : int'(sb.max_radius) * 256;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (i == n/3 && !quiet) hold_asks++;
            if (pick < 40) begin
                add_point(24'($urandom_range(0, 2*lim) - lim),
                          24'($urandom_range(0, 2*lim) - lim));
            end else if (pick < 60) begin
                h = $urandom_range(7);
                add_point(hot_x[h], hot_y[h]);
            end else if (pick < 70) begin
                add_point(24'($urandom), 24'($urandom));
            end else if (pick < 86) begin
                read_cell(5'($urandom_range(19)), 6'($urandom_range(59)));
            end else if (pick < 93) begin
                h = $urandom_range(7);
                read_cell(5'($urandom), 6'($urandom));
            end else if (pick < 96) begin
                send_req(REQ_SPARE, 24'($urandom), 24'($urandom),
                         5'($urandom), 6'($urandom));
            end else if (pick < 97) begin
                send_req(pdd_pkg::REQ_CLEAR, 24'($urandom), 24'($urandom),
                         5'($urandom), 6'($urandom));
            end else begin
                // boundary of the outer ring
                add_point(24'(lim), 24'd0);
            end
        end
    endtask

    // stimulus
    initial begin
        logic [7:0] max_set[6] = '{8'd255, 8'd1, 8'd0, 8'd10, 8'd255, 8'd30};
        logic [7:0] min_set[6] = '{8'd0, 8'd0, 8'd0, 8'd20, 8'd255, 8'd3};
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = pdd_pkg::REQ_ADD;
        i_cfg_valid = 1'b0;
        i_cfg_index = pdd_pkg::CFG_MAX_RADIUS;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        sent        = 0;
        foreach (hot_x[i]) begin
            hot_x[i] = 24'($urandom_range(0, 40000) - 20000);
            hot_y[i] = 24'($urandom_range(0, 40000) - 20000);
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings first
        read_cell(5'd0, 6'd0);
        random_phase(150);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(pdd_pkg::CFG_MAX_RADIUS, max_set[p]);
            write_reg(pdd_pkg::CFG_MIN_RADIUS, min_set[p]);
            if (p == 0) begin
                // directed: origin, axes, quadrants, extremes, odd reads
                add_point(24'sd0, 24'sd0);
                add_point(24'sd1000, 24'sd0);
                add_point(24'sd0, 24'sd1000);
                add_point(-24'sd1000, 24'sd0);
                add_point(24'sd0, -24'sd1000);
                add_point(24'sd3000, 24'sd2000);
                add_point(-24'sd3000, 24'sd2000);
                add_point(-24'sd3000, -24'sd2000);
                add_point(24'sd3000, -24'sd2000);
                add_point(24'sh7FFFFF, 24'sh7FFFFF);
                add_point(24'sh800000, 24'sh800000);
                add_point(24'sd65280, 24'sd0);
                add_point(24'sd65281, 24'sd0);
                add_point(24'sd0, -24'sd65280);
                read_cell(5'd0, 6'd0);
                read_cell(5'd31, 6'd63);
                read_cell(5'd19, 6'd59);
                read_cell(5'd20, 6'd0);
                send_req(REQ_SPARE, 24'sd0, 24'sd0, 5'd0, 6'd15);
                send_req(pdd_pkg::REQ_CLEAR, 24'sh7FFFFF, 24'sh800000, 5'd31, 6'd63);
                read_cell(5'd0, 6'd0);
            end
            quiet = (p == 1);
            add_point(24'sd0, 24'sd0);
            random_phase(180);
            quiet = 1'b0;
            drain();
        end

        // final wait for any stragglers
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("%0d requests sent, %0d results checked (%0d binned, %0d dropped)",
                 sent, sb.checked, sb.binned, sb.dropped);
        $display("seven limit settings including zero, one and full scale");
        if (sb.failures == 0 && sb.pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/pdd_pkg.sv
rtl/pdd_grid_mem.sv
rtl/pdd_cordic.sv
rtl/pdd_divider.sv
rtl/polar_density_descriptor.sv
rtl/pdd_checker.sv
tb/polar_density_descriptor_tb.sv
